FILE: hw/rtl/cursor_list_two_stacks_unit_assert.svh
// assertion macros shared by the cursor list blocks
// each use checks on the rising edge of clk and is masked while arst_n is low
`ifndef CURSOR_LIST_TWO_STACKS_UNIT_ASSERT_SVH
`define CURSOR_LIST_TWO_STACKS_UNIT_ASSERT_SVH

// implication checked in the same cycle
`define CLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the following cycle
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cls_pkg.sv
package cls_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT  = 3'd0,
		MODE_RIGHT   = 3'd1,
		MODE_LEFT    = 3'd2,
		MODE_DELETE  = 3'd3,
		MODE_OBSERVE = 3'd4
	} cls_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} cls_status_t;

	// push alone shifts deeper, pop alone shifts up, both replace the top
	typedef struct packed {
		logic push;
		logic pop;
	} cls_stack_ctrl_t;

	typedef struct packed {
		logic empty;
		logic single;
		logic full;
	} cls_stack_stat_t;

endpackage

FILE: hw/rtl/cls_cell.sv
module cls_cell (
	input  logic                        clk,
	input  cls_pkg::cls_stack_ctrl_t    ctrl,
	input  logic [cls_pkg::DATA_W-1:0]  up_data,
	input  logic [cls_pkg::DATA_W-1:0]  down_data,
	output logic [cls_pkg::DATA_W-1:0]  q
);

	logic [cls_pkg::DATA_W-1:0] value_q;

	// push or replace takes from above, pop from below
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			value_q <= up_data;
		end else if (ctrl.pop) begin
			value_q <= down_data;
		end
	end

	assign q = value_q;

endmodule

FILE: hw/rtl/cls_stack.sv
`include "cursor_list_two_stacks_unit_assert.svh"

module cls_stack #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cls_pkg::cls_stack_ctrl_t    ctrl,
	input  logic [cls_pkg::DATA_W-1:0]  push_data,
	output logic [cls_pkg::DATA_W-1:0]  top,
	output logic [cls_pkg::DATA_W-1:0]  second,
	output cls_pkg::cls_stack_stat_t    stat
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]          count_q;
	logic [cls_pkg::DATA_W-1:0] cell_q [DEPTH];

	// cell 0 is the top, data walks one cell per push or pop
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cls_pkg::cls_stack_ctrl_t   cell_ctrl;
		logic [cls_pkg::DATA_W-1:0] up_d;
		logic [cls_pkg::DATA_W-1:0] down_d;

		if (i == 0) begin : g_head
			assign cell_ctrl = ctrl;
			assign up_d      = push_data;
		end else begin : g_body
			// a top replacement leaves the deeper cells alone
			assign cell_ctrl = (ctrl.push && ctrl.pop) ? '0 : ctrl;
			assign up_d      = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign down_d = '0;
		end else begin : g_mid
			assign down_d = cell_q[i+1];
		end

		cls_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.up_data   (up_d),
			.down_data (down_d),
			.q         (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push && !ctrl.pop) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop && !ctrl.push) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign top         = cell_q[0];
	assign second      = cell_q[1];
	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CNT_W'(1));
	assign stat.full   = (count_q == CNT_W'(DEPTH));

	`CLS_ASSERT_NOW(a_no_pop_empty, ctrl.pop && !ctrl.push, !stat.empty, "pop on empty stack")
	`CLS_ASSERT_NOW(a_no_push_full, ctrl.push && !ctrl.pop, !stat.full, "push on full stack")
	`CLS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "count beyond depth")

endmodule

FILE: hw/rtl/cursor_list_two_stacks_unit.sv
// cursor list held as two stacks of shifting cells. the right stack holds the
// active element in its top cell with the elements to its right beneath it;
// the left stack holds the elements left of the cursor, nearest on top. each
// stack is a row of STACK_DEPTH cells that shift one place on a push or a pop,
// so one beat is taken per clock while the output is not stalled, and
// its result beat appears on the master side on the following cycle, held in
// an output register. while a held result is stalled the slave side is held
// off; the next beat is taken in the same cycle as the held result leaves.
// every beat yields one result: the active value (zero when empty), a
// non-empty flag and a status (ok, empty sequence, store full). a full or
// empty case leaves the list unchanged. no clearing pass after reset.
`include "cursor_list_two_stacks_unit_assert.svh"

module cursor_list_two_stacks_unit #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] car_value
	input  logic [2:0]  s_tuser,    // [2:0] mode
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] active_value
	output logic [2:0]  m_tuser     // [0] not_empty, [2:1] status
);

	cls_pkg::cls_stack_ctrl_t   r_ctrl, l_ctrl;
	cls_pkg::cls_stack_stat_t   r_stat, l_stat;
	logic [cls_pkg::DATA_W-1:0] r_top, r_second, l_top, r_push_data;
	cls_pkg::cls_status_t       status_d;
	cls_pkg::cls_mode_t         mode;
	logic                       in_beat;
	logic [cls_pkg::DATA_W-1:0] active_d;
	logic                       not_empty_d;

	logic                       m_tvalid_q;
	logic [cls_pkg::DATA_W-1:0] active_q;
	logic                       not_empty_q;
	cls_pkg::cls_status_t       status_q;

	// right stack: active element and everything to its right
	cls_stack #(.DEPTH(STACK_DEPTH)) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (r_ctrl),
		.push_data (r_push_data),
		.top       (r_top),
		.second    (r_second),
		.stat      (r_stat)
	);

	// left stack: elements left of the cursor, nearest on top
	cls_stack #(.DEPTH(STACK_DEPTH)) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (l_ctrl),
		.push_data (r_top),
		.top       (l_top),
		.second    (),
		.stat      (l_stat)
	);

	// new beat taken when the output register is empty or drains this cycle
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;
	assign mode     = cls_pkg::cls_mode_t'(s_tuser);

	// decode the operation into stack moves, gated by the input beat
	always_comb begin
		r_ctrl      = '0;
		l_ctrl      = '0;
		r_push_data = s_tdata;
		status_d    = cls_pkg::STATUS_OK;
		case (mode)
			cls_pkg::MODE_INSERT: begin
				if (r_stat.full) begin
					status_d = cls_pkg::STATUS_FULL;
				end else begin
					r_ctrl.push = 1'b1;
				end
			end
			cls_pkg::MODE_RIGHT: begin
				// only moves when a further right element exists
				if (!r_stat.empty && !r_stat.single) begin
					if (l_stat.full) begin
						status_d = cls_pkg::STATUS_FULL;
					end else begin
						l_ctrl.push = 1'b1;
						r_ctrl.pop  = 1'b1;
					end
				end
			end
			cls_pkg::MODE_LEFT: begin
				if (!l_stat.empty) begin
					if (r_stat.full) begin
						status_d = cls_pkg::STATUS_FULL;
					end else begin
						r_ctrl.push = 1'b1;
						r_push_data = l_top;
						l_ctrl.pop  = 1'b1;
					end
				end
			end
			cls_pkg::MODE_DELETE: begin
				if (r_stat.empty) begin
					status_d = cls_pkg::STATUS_EMPTY;
				end else if (r_stat.single && !l_stat.empty) begin
					// last right element goes, left top takes its place
					r_ctrl.push = 1'b1;
					r_ctrl.pop  = 1'b1;
					r_push_data = l_top;
					l_ctrl.pop  = 1'b1;
				end else begin
					r_ctrl.pop = 1'b1;
				end
			end
			default: begin
				// observe, and the unused codes behave the same
				if (r_stat.empty) begin
					status_d = cls_pkg::STATUS_EMPTY;
				end
			end
		endcase
		if (!in_beat) begin
			r_ctrl = '0;
			l_ctrl = '0;
		end
	end

	// active element as it will stand after the move
	always_comb begin
		if (r_ctrl.push) begin
			active_d    = r_push_data;
			not_empty_d = 1'b1;
		end else if (r_ctrl.pop) begin
			active_d    = r_stat.single ? '0 : r_second;
			not_empty_d = !r_stat.single;
		end else begin
			active_d    = r_stat.empty ? '0 : r_top;
			not_empty_d = !r_stat.empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_beat) begin
			active_q    <= active_d;
			not_empty_q <= not_empty_d;
			status_q    <= status_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = active_q;
	assign m_tuser  = {status_q, not_empty_q};

	// no move ever leaves elements only on the left
	`CLS_ASSERT_NOW(a_left_needs_right, r_stat.empty, l_stat.empty, "left holds data, right empty")
	// an empty result carries a zero value
	`CLS_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "empty result nonzero")
	// observe and delete never report a full store
	`CLS_ASSERT_NEXT(a_no_full_observe,
		in_beat && (mode == cls_pkg::MODE_OBSERVE || mode == cls_pkg::MODE_DELETE),
		m_tuser[2:1] != cls_pkg::STATUS_FULL, "full status on observe or delete")

endmodule
